### hdl/crystal_keyword_number_extractor_top_macros.svh
// Assertion macros used by the keyword number extractor parser.
`ifndef CRYSTAL_KEYWORD_NUMBER_EXTRACTOR_TOP_MACROS_SVH
`define CRYSTAL_KEYWORD_NUMBER_EXTRACTOR_TOP_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define CKEN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CKEN_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CKEN_ASSERT(name, prop, msg)
`define CKEN_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### hdl/cken_pkg.sv
// Types and constants shared by the keyword number extractor modules.
`timescale 1ns / 1ps
`default_nettype none
package cken_pkg;

  // Parser modes, one-hot.
  typedef enum logic [7:0] {
    MODE_WAIT   = 8'b0000_0001,
    MODE_NEWCMD = 8'b0000_0010,
    MODE_MATCH  = 8'b0000_0100,
    MODE_SKIP   = 8'b0000_1000,
    MODE_CELL   = 8'b0001_0000,
    MODE_LENGTH = 8'b0010_0000,
    MODE_NUMBER = 8'b0100_0000,
    MODE_DONE   = 8'b1000_0000
  } mode_t;

  // Characters that steer the parser.
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharPoint      = 8'h2E;
  localparam logic [7:0] CharDigit0     = 8'd48;
  localparam logic [7:0] CharDigit9     = 8'd57;
  localparam logic [7:0] CharC          = 8'h63;
  localparam logic [7:0] CharL          = 8'h6C;
  localparam logic [7:0] CharA          = 8'h61;

  // Keyword lengths: "ell" after 'c', "ength" after 'l'.
  localparam logic [2:0] LenEll   = 3'd3;
  localparam logic [2:0] LenEngth = 3'd5;

  // Largest fraction digit count.
  localparam logic [3:0] FracMax = 4'd15;

  // One input word.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_file;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [31:0] value_mantissa;
    logic [3:0]  fraction_digits;
    logic        digit_seen;
    logic        overflow;
  } result_t;

  // Expected letter of the keyword being matched.
  function automatic logic [7:0] keyword_char(input logic sel, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (!sel) begin
      case (idx)
        3'd0: ch = 8'h65;
        3'd1: ch = 8'h6C;
        3'd2: ch = 8'h6C;
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0: ch = 8'h65;
        3'd1: ch = 8'h6E;
        3'd2: ch = 8'h67;
        3'd3: ch = 8'h74;
        3'd4: ch = 8'h68;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

### hdl/crystal_keyword_number_extractor_top.sv
// Top level of the keyword number extractor.
// Usage:
//   The input channel carries one word per character: char_code and
//   end_of_file, accepted when item_valid is high and item_stall is low.
//   The block scans the text for "_cell", "_length" and "_a" and parses the
//   number that follows. Each finished number leaves on the result channel
//   as value_mantissa, fraction_digits, digit_seen and overflow, accepted when
//   result_valid is high and result_stall is low.
//   result_valid rises once the word ending the number has passed the input
//   register and the parser's result has loaded into the result register.
//   Throughput: one word per cycle while the result register is free; the
//   parser step with its multiply-by-ten adder is the whole per-word work.
//   When the receiver stalls, the result register holds its word, the parser
//   stops, and item_stall rises once the input register is full.
//   Synchronous reset clears the valid flags of both registers and returns the
//   parser to waiting for an underscore. After end of file every word is consumed
//   with no result until the next reset.
`timescale 1ns / 1ps
`default_nettype none
module crystal_keyword_number_extractor_top #(
  parameter int MANTISSA_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_file,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      value_mantissa,
  output logic [3:0]       fraction_digits,
  output logic             digit_seen,
  output logic             overflow
);
  import cken_pkg::*;

  logic    held_valid;
  item_t   held_item;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t result;

  // Input register.
  cken_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_code  (char_code),
    .end_of_file(end_of_file),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Parser step.
  cken_parser #(
    .MANTISSA_BITS(MANTISSA_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .held_valid(held_valid),
    .held_item (held_item),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  cken_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .out_free    (out_free),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // Result fields to ports.
  assign value_mantissa  = result.value_mantissa;
  assign fraction_digits = result.fraction_digits;
  assign digit_seen      = result.digit_seen;
  assign overflow        = result.overflow;

endmodule
`default_nettype wire

### hdl/cken_in_stage.sv
// Input register that holds one word until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module cken_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire logic [7:0]      char_code,
  input  wire logic            end_of_file,
  input  wire logic            take,
  output logic                 held_valid,
  output cken_pkg::item_t      held_item
);
  import cken_pkg::*;

  logic accept;

  // The register is free when empty or when its word leaves this cycle.
  assign item_stall = held_valid && !take;
  assign accept     = item_valid && !item_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.char_code   <= char_code;
      held_item.end_of_file <= end_of_file;
    end
  end

endmodule
`default_nettype wire

### hdl/cken_parser.sv
// Keyword matcher and decimal number accumulator, one character per cycle while the result register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "crystal_keyword_number_extractor_top_macros.svh"
module cken_parser #(
  parameter int MANTISSA_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              held_valid,
  input  wire cken_pkg::item_t   held_item,
  input  wire logic              out_free,
  output logic                   take,
  output logic                   res_valid,
  output cken_pkg::result_t      res
);
  import cken_pkg::*;

  localparam int AccW  = (MANTISSA_BITS < 32) ? MANTISSA_BITS : 32;
  localparam int ProdW = AccW + 4;

  mode_t             mode, mode_next;
  logic              sel, sel_next;
  logic [2:0]        idx, idx_next;
  logic [AccW-1:0]   acc, acc_next;
  logic [3:0]        frac, frac_next;
  logic              point, point_next;
  logic              digit, digit_next;
  logic              sat, sat_next;

  logic [7:0]        ch;
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [ProdW-1:0]  prod;
  logic              prod_over;
  logic [2:0]        kw_len;
  logic [2:0]        idx_inc;
  logic [7:0]        want;

  // A word is processed when the result register can take its result.
  assign take = held_valid && out_free;
  assign ch   = held_item.char_code;

  // Multiply by ten as two shifts and an add, then add the new digit.
  assign is_digit  = (ch >= CharDigit0) && (ch <= CharDigit9);
  assign digit_val = 4'(ch - CharDigit0);
  assign prod      = ProdW'({acc, 3'b000}) + ProdW'({acc, 1'b0}) + ProdW'(digit_val);
  assign prod_over = |prod[ProdW-1:AccW];

  // Keyword lookup.
  assign kw_len  = sel ? LenEngth : LenEll;
  assign idx_inc = idx + 3'd1;
  assign want    = keyword_char(sel, idx);

  // Result word from the current number state.
  always_comb begin
    res.value_mantissa  = digit ? 32'(acc) : 32'd0;
    res.fraction_digits = digit ? frac : 4'd0;
    res.digit_seen      = digit;
    res.overflow        = sat;
  end

  // Next-state logic.
  always_comb begin
    mode_next  = mode;
    sel_next   = sel;
    idx_next   = idx;
    acc_next   = acc;
    frac_next  = frac;
    point_next = point;
    digit_next = digit;
    sat_next   = sat;
    res_valid  = 1'b0;
    if (take && (mode != MODE_DONE)) begin
      if (held_item.end_of_file) begin
        res_valid = (mode == MODE_NUMBER);
        mode_next = MODE_DONE;
      end else begin
        case (mode)
          MODE_WAIT: begin
            if (ch == CharUnderscore) mode_next = MODE_NEWCMD;
          end
          MODE_NEWCMD: begin
            if (ch == CharC) begin
              mode_next = MODE_MATCH;
              sel_next  = 1'b0;
              idx_next  = 3'd0;
            end else if (ch != CharUnderscore) begin
              mode_next = MODE_WAIT;
            end
          end
          MODE_MATCH: begin
            if (idx >= kw_len) begin
              mode_next = MODE_WAIT;
            end else if (ch == CharUnderscore) begin
              mode_next = MODE_NEWCMD;
            end else if (ch != want) begin
              mode_next = MODE_WAIT;
            end else begin
              idx_next = idx_inc;
              if (idx_inc >= kw_len) mode_next = MODE_SKIP;
            end
          end
          MODE_SKIP: begin
            if (ch == CharUnderscore) mode_next = sel ? MODE_LENGTH : MODE_CELL;
          end
          MODE_CELL: begin
            if (ch == CharL) begin
              mode_next = MODE_MATCH;
              sel_next  = 1'b1;
              idx_next  = 3'd0;
            end else if (ch == CharUnderscore) begin
              mode_next = MODE_NEWCMD;
            end else begin
              mode_next = MODE_WAIT;
            end
          end
          MODE_LENGTH: begin
            if (ch == CharA) begin
              mode_next  = MODE_NUMBER;
              acc_next   = '0;
              frac_next  = 4'd0;
              point_next = 1'b0;
              digit_next = 1'b0;
              sat_next   = 1'b0;
            end else if (ch == CharUnderscore) begin
              mode_next = MODE_NEWCMD;
            end else begin
              mode_next = MODE_WAIT;
            end
          end
          MODE_NUMBER: begin
            if (ch == CharUnderscore) begin
              res_valid = 1'b1;
              mode_next = MODE_NEWCMD;
            end else if (ch == CharPoint) begin
              if (!point) begin
                point_next = 1'b1;
              end else begin
                res_valid = 1'b1;
                mode_next = MODE_WAIT;
              end
            end else if (is_digit) begin
              digit_next = 1'b1;
              if (!point) begin
                if (prod_over) begin
                  acc_next = '1;
                  sat_next = 1'b1;
                end else begin
                  acc_next = prod[AccW-1:0];
                end
              end else begin
                if (prod_over || (frac >= FracMax)) begin
                  sat_next = 1'b1;
                end else begin
                  acc_next  = prod[AccW-1:0];
                  frac_next = frac + 4'd1;
                end
              end
            end else if (digit) begin
              res_valid = 1'b1;
              mode_next = MODE_WAIT;
            end
          end
          MODE_DONE: begin
            mode_next = MODE_DONE;
          end
          default: begin
            mode_next = MODE_WAIT;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_WAIT;
      sel   <= 1'b0;
      idx   <= 3'd0;
      acc   <= '0;
      frac  <= 4'd0;
      point <= 1'b0;
      digit <= 1'b0;
      sat   <= 1'b0;
    end else begin
      mode  <= mode_next;
      sel   <= sel_next;
      idx   <= idx_next;
      acc   <= acc_next;
      frac  <= frac_next;
      point <= point_next;
      digit <= digit_next;
      sat   <= sat_next;
    end
  end

  // Once stopped, the parser stays stopped until reset.
  `CKEN_ASSERT(a_done_sticky, (mode == MODE_DONE) |=> (mode == MODE_DONE), "left stopped mode")
  // Without a digit the accumulators are still clear.
  `CKEN_ASSERT(a_clear_without_digit, (!digit) |-> ((acc == '0) && (frac == 4'd0)), "dirty number")
  // Fraction digits only count after a point.
  `CKEN_ASSERT(a_frac_needs_point, (frac != 4'd0) |-> point, "fraction without point")

endmodule
`default_nettype wire

### hdl/cken_out_stage.sv
// Result register that holds a word while the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none
module cken_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire cken_pkg::result_t res,
  output logic                   out_free,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cken_pkg::result_t      result
);
  import cken_pkg::*;

  // The register can load when empty or when its word is taken now.
  assign out_free = !result_valid || !result_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= res_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      result <= res;
    end
  end

endmodule
`default_nettype wire
